// ===== hdl/rc_channel_frame_parser_macros.svh =====
// Assertion macros for the RC channel frame parser.
// Both macros assume a clock clk_i and an active-low reset rst_ni in scope.
`ifndef RC_CHANNEL_FRAME_PARSER_MACROS_SVH
`define RC_CHANNEL_FRAME_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset
`define RCFP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen outside reset
`define RCFP_ASSERT_NEVER(name, cond, msg) \
  `RCFP_ASSERT(name, !(cond), msg)

`else

`define RCFP_ASSERT(name, prop, msg)
`define RCFP_ASSERT_NEVER(name, cond, msg)

`endif

`endif

// ===== hdl/rcfp_pkg.sv =====
package rcfp_pkg;

  // Frame format
  localparam int unsigned PAYLOAD_BYTES = 22;
  localparam int unsigned PAYLOAD_W     = PAYLOAD_BYTES * 8;
  localparam int unsigned CHAN_BITS     = 11;
  localparam int unsigned IDX_BITS      = 4;
  localparam int unsigned CNT_BITS      = 5;
  localparam int unsigned NUM_CHANNELS_DEF = 16;

  localparam logic [7:0] LEN_BYTE      = 8'(PAYLOAD_BYTES + 2);
  localparam logic [7:0] FRAME_TYPE_RC = 8'h16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = CHAN_BITS;

  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_PRI = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_SEC = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN_MID = 3'd4;

  // Register reset values
  localparam logic [7:0]           RST_ADDR_PRI = 8'd200;
  localparam logic [7:0]           RST_ADDR_SEC = 8'd0;
  localparam logic [CHAN_BITS-1:0] RST_CHAN_MIN = 11'd172;
  localparam logic [CHAN_BITS-1:0] RST_CHAN_MAX = 11'd1811;
  localparam logic [CHAN_BITS-1:0] RST_CHAN_MID = 11'd992;

endpackage

// ===== hdl/rc_channel_frame_parser.sv =====
// Packed RC-channels frame parser. Received bytes arrive one beat at a time on
// the input channel: an address byte matching either address register, a
// length byte of 24, the type byte 0x16, 22 payload bytes and a trailer byte
// (not checked as a CRC). A bad length or type byte drops the frame. After the
// trailer beat the payload, held in a 176-bit shift register, is unpacked by
// one shared 11-bit shift and range-compare step that produces one channel per
// cycle while the output is not stalled. After the trailer beat in_stall_o
// stays high until the last channel has been handed to the output register.
// Each output beat carries channel index, value (channel_mid if the raw value
// lies outside channel_min..channel_max), the out-of-range flag and a last flag.
`include "rc_channel_frame_parser_macros.svh"

module rc_channel_frame_parser #(
  parameter int unsigned NUM_CHANNELS = rcfp_pkg::NUM_CHANNELS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [rcfp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rcfp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // received bytes
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       rx_byte_i,
  // channel results
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [rcfp_pkg::IDX_BITS-1:0]    channel_index_o,
  output logic [rcfp_pkg::CHAN_BITS-1:0]   channel_value_o,
  output logic                             out_of_range_o,
  output logic                             last_channel_o
);

  localparam int unsigned PW = rcfp_pkg::PAYLOAD_W;
  localparam int unsigned CB = rcfp_pkg::CHAN_BITS;
  localparam int unsigned IB = rcfp_pkg::IDX_BITS;
  localparam int unsigned NB = rcfp_pkg::CNT_BITS;
  localparam logic [IB-1:0] LAST_IDX = IB'(NUM_CHANNELS - 1);
  localparam logic [NB-1:0] LAST_BYTE = NB'(rcfp_pkg::PAYLOAD_BYTES - 1);

  typedef enum logic [2:0] {
    ST_ADDR,
    ST_SIZE,
    ST_TYPE,
    ST_PAYLOAD,
    ST_TRAILER,
    ST_EMIT
  } state_e;

  state_e          state_q, state_d;
  logic [NB-1:0]   byte_cnt_q, byte_cnt_d;
  logic [IB-1:0]   chan_cnt_q, chan_cnt_d;
  logic [PW-1:0]   payload_q, payload_d;

  logic [7:0]      addr_pri_q, addr_sec_q;
  logic [CB-1:0]   chan_min_q, chan_max_q, chan_mid_q;

  logic            out_valid_q, out_valid_d;
  logic [IB-1:0]   out_idx_q, out_idx_d;
  logic [CB-1:0]   out_val_q, out_val_d;
  logic            out_oor_q, out_oor_d;
  logic            out_last_q, out_last_d;

  logic            in_acc;
  logic            out_free;
  logic [CB-1:0]   raw_chan;
  logic            raw_bad;

  assign in_stall_o = (state_q == ST_EMIT);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // shared unit: lowest 11 bits of the shift register against the limits
  assign raw_chan = payload_q[CB-1:0];
  assign raw_bad  = (raw_chan < chan_min_q) || (raw_chan > chan_max_q);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_pri_q <= rcfp_pkg::RST_ADDR_PRI;
      addr_sec_q <= rcfp_pkg::RST_ADDR_SEC;
      chan_min_q <= rcfp_pkg::RST_CHAN_MIN;
      chan_max_q <= rcfp_pkg::RST_CHAN_MAX;
      chan_mid_q <= rcfp_pkg::RST_CHAN_MID;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rcfp_pkg::CFG_ADDR_PRI: addr_pri_q <= cfg_data_i[7:0];
        rcfp_pkg::CFG_ADDR_SEC: addr_sec_q <= cfg_data_i[7:0];
        rcfp_pkg::CFG_CHAN_MIN: chan_min_q <= cfg_data_i;
        rcfp_pkg::CFG_CHAN_MAX: chan_max_q <= cfg_data_i;
        rcfp_pkg::CFG_CHAN_MID: chan_mid_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    byte_cnt_d  = byte_cnt_q;
    chan_cnt_d  = chan_cnt_q;
    payload_d   = payload_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_idx_d   = out_idx_q;
    out_val_d   = out_val_q;
    out_oor_d   = out_oor_q;
    out_last_d  = out_last_q;

    case (state_q)
      ST_ADDR: begin
        if (in_acc && (rx_byte_i == addr_pri_q || rx_byte_i == addr_sec_q)) begin
          state_d = ST_SIZE;
        end
      end
      ST_SIZE: begin
        if (in_acc) begin
          state_d = (rx_byte_i == rcfp_pkg::LEN_BYTE) ? ST_TYPE : ST_ADDR;
        end
      end
      ST_TYPE: begin
        if (in_acc) begin
          byte_cnt_d = '0;
          state_d    = (rx_byte_i == rcfp_pkg::FRAME_TYPE_RC) ? ST_PAYLOAD : ST_ADDR;
        end
      end
      ST_PAYLOAD: begin
        // bytes shift in from the top, so byte k ends at bits 8k+7:8k
        if (in_acc) begin
          if (byte_cnt_q > LAST_BYTE) begin
            state_d = ST_ADDR;
          end else begin
            payload_d  = {rx_byte_i, payload_q[PW-1:8]};
            byte_cnt_d = byte_cnt_q + NB'(1);
            if (byte_cnt_q == LAST_BYTE) begin
              state_d = ST_TRAILER;
            end
          end
        end
      end
      ST_TRAILER: begin
        if (in_acc) begin
          chan_cnt_d = '0;
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // one channel per cycle whenever the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = chan_cnt_q;
          out_val_d   = raw_bad ? chan_mid_q : raw_chan;
          out_oor_d   = raw_bad;
          out_last_d  = (chan_cnt_q == LAST_IDX);
          payload_d   = {{CB{1'b0}}, payload_q[PW-1:CB]};
          chan_cnt_d  = chan_cnt_q + IB'(1);
          if (chan_cnt_q == LAST_IDX) begin
            state_d = ST_ADDR;
          end
        end
      end
      default: begin
        state_d = ST_ADDR;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ADDR;
      byte_cnt_q  <= '0;
      chan_cnt_q  <= '0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_val_q   <= '0;
      out_oor_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      byte_cnt_q  <= byte_cnt_d;
      chan_cnt_q  <= chan_cnt_d;
      out_valid_q <= out_valid_d;
      out_idx_q   <= out_idx_d;
      out_val_q   <= out_val_d;
      out_oor_q   <= out_oor_d;
      out_last_q  <= out_last_d;
    end
  end

  // payload shift register
  always_ff @(posedge clk_i) begin
    payload_q <= payload_d;
  end

  assign out_valid_o     = out_valid_q;
  assign channel_index_o = out_idx_q;
  assign channel_value_o = out_val_q;
  assign out_of_range_o  = out_oor_q;
  assign last_channel_o  = out_last_q;

  // checks
  `RCFP_ASSERT(a_trailer_starts_emit,
               (in_acc && state_q == ST_TRAILER) |=> (state_q == ST_EMIT),
               "trailer beat did not start channel output")
  `RCFP_ASSERT_NEVER(a_last_index,
                     out_valid_o && last_channel_o && (channel_index_o != LAST_IDX),
                     "last flag on a channel other than the final one")

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int unsigned NUM_CH       = rcfp_pkg::NUM_CHANNELS_DEF;
  localparam int unsigned PAYLOAD_BYTES = rcfp_pkg::PAYLOAD_BYTES;
  localparam int unsigned PAYLOAD_W    = rcfp_pkg::PAYLOAD_W;
  localparam int unsigned CHAN_BITS    = rcfp_pkg::CHAN_BITS;
  localparam int unsigned IDX_BITS     = rcfp_pkg::IDX_BITS;
  localparam int unsigned CFG_IDX_W    = rcfp_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W   = rcfp_pkg::CFG_DATA_W;
  localparam int unsigned DRAIN_CYCLES = NUM_CH + 8;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned PHASE_ITEMS  = 10;
  localparam int unsigned FRAME_ITEMS  = PAYLOAD_BYTES + 4;

  // Decoder progress through one frame
  typedef enum logic [2:0] {
    WAIT_ADDR,
    WAIT_LEN,
    WAIT_TYPE,
    IN_PAYLOAD,
    WAIT_TRAILER
  } parse_phase_e;

  // One channel beat on the output side
  typedef struct packed {
    logic [IDX_BITS-1:0]  chan;
    logic [CHAN_BITS-1:0] value;
    logic                 oor;
    logic                 last;
  } chan_beat_t;

  typedef logic [CHAN_BITS-1:0] chan_set_t [NUM_CH];

  // Tracks the frame decoder and holds the channel beats still due
  class rc_frame_tracker;
    logic [7:0]           addr_pri;
    logic [7:0]           addr_sec;
    logic [CHAN_BITS-1:0] ch_min;
    logic [CHAN_BITS-1:0] ch_max;
    logic [CHAN_BITS-1:0] ch_mid;
    parse_phase_e         phase;
    int unsigned          stored;
    logic [PAYLOAD_W-1:0] payload;
    chan_beat_t           due[$];
    int unsigned          errors;
    int unsigned          beats_seen;

    function new();
      addr_pri   = rcfp_pkg::RST_ADDR_PRI;
      addr_sec   = rcfp_pkg::RST_ADDR_SEC;
      ch_min     = rcfp_pkg::RST_CHAN_MIN;
      ch_max     = rcfp_pkg::RST_CHAN_MAX;
      ch_mid     = rcfp_pkg::RST_CHAN_MID;
      phase      = WAIT_ADDR;
      stored     = 0;
      payload    = '0;
      errors     = 0;
      beats_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        rcfp_pkg::CFG_ADDR_PRI: addr_pri = data[7:0];
        rcfp_pkg::CFG_ADDR_SEC: addr_sec = data[7:0];
        rcfp_pkg::CFG_CHAN_MIN: ch_min = data;
        rcfp_pkg::CFG_CHAN_MAX: ch_max = data;
        rcfp_pkg::CFG_CHAN_MID: ch_mid = data;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction

    // Advance the decoder by one accepted byte; the trailer releases all channels
    function void take_byte(logic [7:0] b);
      logic [CHAN_BITS-1:0] raw;
      chan_beat_t           beat;
      case (phase)
        WAIT_ADDR: begin
          if (b == addr_pri || b == addr_sec) phase = WAIT_LEN;
        end
        WAIT_LEN: begin
          phase = (b == rcfp_pkg::LEN_BYTE) ? WAIT_TYPE : WAIT_ADDR;
        end
        WAIT_TYPE: begin
          if (b == rcfp_pkg::FRAME_TYPE_RC) begin
            stored = 0;
            phase  = IN_PAYLOAD;
          end else begin
            phase = WAIT_ADDR;
          end
        end
        IN_PAYLOAD: begin
          payload[8*stored +: 8] = b;
          stored++;
          if (stored >= PAYLOAD_BYTES) phase = WAIT_TRAILER;
        end
        WAIT_TRAILER: begin
          for (int ch = 0; ch < NUM_CH; ch++) begin
            raw        = payload[ch*CHAN_BITS +: CHAN_BITS];
            beat.chan  = IDX_BITS'(ch);
            beat.oor   = (raw < ch_min) || (raw > ch_max);
            beat.value = beat.oor ? ch_mid : raw;
            beat.last  = (ch == NUM_CH - 1);
            due.push_back(beat);
          end
          phase = WAIT_ADDR;
        end
        default: phase = WAIT_ADDR;
      endcase
    endfunction

    function void compare_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch on beat %0d: expected %0d, got %0d",
                 $time, what, beats_seen, want, got);
      end
    endfunction

    function void check_beat(chan_beat_t got);
      chan_beat_t want;
      beats_seen++;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat: expected none, got chan %0d value %0d oor %0b last %0b",
                 $time, got.chan, got.value, got.oor, got.last);
        return;
      end
      want = due.pop_front();
      compare_field("channel_index", want.chan, got.chan);
      compare_field("channel_value", want.value, got.value);
      compare_field("out_of_range", want.oor, got.oor);
      compare_field("last_channel", want.last, got.last);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [7:0]            rx_byte_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [IDX_BITS-1:0]   channel_index_o;
  logic [CHAN_BITS-1:0]  channel_value_o;
  logic                  out_of_range_o;
  logic                  last_channel_o;

  rc_frame_tracker sb = new();
  bit              idle_on   = 1'b1;
  bit              hold_long = 1'b0;

  rc_channel_frame_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .out_of_range_o  (out_of_range_o),
    .last_channel_o  (last_channel_o)
  );

  always #2 clk_i = ~clk_i;

  // Output beats go straight to the checker
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o && !out_stall_i)
      sb.check_beat('{chan: channel_index_o, value: channel_value_o,
                      oor: out_of_range_o, last: last_channel_o});
  end

  // Receiver back-pressure: random bursts, plus one long hold-off on request
  initial begin
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_long) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_long = 1'b0;
        out_stall_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // One byte beat, with an occasional idle burst in front of it
  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_byte(b);
  endtask

  function automatic logic [PAYLOAD_W-1:0] pack_channels(input chan_set_t c);
    logic [PAYLOAD_W-1:0] p;
    p = '0;
    for (int ch = 0; ch < NUM_CH; ch++) p[ch*CHAN_BITS +: CHAN_BITS] = c[ch];
    return p;
  endfunction

  // Channel value biased towards the range limits
  function automatic logic [CHAN_BITS-1:0] pick_channel();
    case ($urandom_range(0, 7))
      0: return sb.ch_min;
      1: return sb.ch_max;
      2: return sb.ch_min - 1'b1;
      3: return sb.ch_max + 1'b1;
      4: return '0;
      5: return '1;
      default: return CHAN_BITS'($urandom);
    endcase
  endfunction

  task automatic send_frame(input logic [7:0] addr, input logic [PAYLOAD_W-1:0] p,
                            input logic [7:0] trailer);
    send_byte(addr);
    send_byte(rcfp_pkg::LEN_BYTE);
    send_byte(rcfp_pkg::FRAME_TYPE_RC);
    for (int i = 0; i < PAYLOAD_BYTES; i++) send_byte(p[8*i +: 8]);
    send_byte(trailer);
  endtask

  // Mostly good frames with random content; the rest noise and broken headers
  task automatic random_sequence(output int unsigned n_items);
    int unsigned          kind;
    logic [7:0]           addr;
    logic [7:0]           b;
    logic [PAYLOAD_W-1:0] p;
    chan_set_t            c;
    kind = $urandom_range(0, 9);
    addr = $urandom_range(0, 1) ? sb.addr_pri : sb.addr_sec;
    if (kind < 6) begin
      if ($urandom_range(0, 1)) begin
        for (int i = 0; i < PAYLOAD_BYTES; i++) p[8*i +: 8] = 8'($urandom);
      end else begin
        for (int ch = 0; ch < NUM_CH; ch++) c[ch] = pick_channel();
        p = pack_channels(c);
      end
      send_frame(addr, p, 8'($urandom));
      n_items = FRAME_ITEMS;
    end else if (kind == 6) begin
      send_byte(8'($urandom));
      n_items = 1;
    end else if (kind == 7) begin
      do b = 8'($urandom); while (b == rcfp_pkg::LEN_BYTE);
      send_byte(addr);
      send_byte(b);
      n_items = 2;
    end else begin
      do b = 8'($urandom); while (b == rcfp_pkg::FRAME_TYPE_RC);
      send_byte(addr);
      send_byte(rcfp_pkg::LEN_BYTE);
      send_byte(b);
      n_items = 3;
    end
  endtask

  task automatic run_phase(input int unsigned quota);
    int unsigned done;
    int unsigned k;
    done = 0;
    while (done < quota) begin
      random_sequence(k);
      done += k;
    end
  endtask

  // Let the block drain before touching its registers
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Address writes carry junk in the unused upper data bits
  task automatic apply_settings(input logic [7:0] pri, input logic [7:0] sec,
                                input logic [CHAN_BITS-1:0] mn, input logic [CHAN_BITS-1:0] mx,
                                input logic [CHAN_BITS-1:0] md);
    set_reg(rcfp_pkg::CFG_ADDR_PRI, {3'($urandom), pri});
    set_reg(rcfp_pkg::CFG_ADDR_SEC, {3'($urandom), sec});
    set_reg(rcfp_pkg::CFG_CHAN_MIN, mn);
    set_reg(rcfp_pkg::CFG_CHAN_MAX, mx);
    set_reg(rcfp_pkg::CFG_CHAN_MID, md);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    chan_set_t limits;
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= rcfp_pkg::CFG_ADDR_PRI;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    rx_byte_i  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Bad length equal to an address: dropped and not retried as an address
    send_byte(rcfp_pkg::RST_ADDR_PRI);
    send_byte(rcfp_pkg::RST_ADDR_PRI);
    send_byte(rcfp_pkg::LEN_BYTE);
    // Bad type byte after the secondary address
    send_byte(rcfp_pkg::RST_ADDR_SEC);
    send_byte(rcfp_pkg::LEN_BYTE);
    send_byte(8'hFF);
    // Full frame with channels on and around the reset range limits
    limits = '{11'd0, 11'd2047, rcfp_pkg::RST_CHAN_MIN - 11'd1, rcfp_pkg::RST_CHAN_MIN,
               rcfp_pkg::RST_CHAN_MAX, rcfp_pkg::RST_CHAN_MAX + 11'd1, rcfp_pkg::RST_CHAN_MID,
               11'd1, 11'd2046, 11'd1024, 11'd1023, rcfp_pkg::RST_CHAN_MIN,
               rcfp_pkg::RST_CHAN_MAX, 11'd0, 11'd2047, 11'd1000};
    send_frame(rcfp_pkg::RST_ADDR_PRI, pack_channels(limits), 8'h00);
    run_phase(PHASE_ITEMS);

    // Both addresses alike, full range open, zero midpoint; unused indexes ignored
    settle();
    apply_settings(8'hFF, 8'hFF, '0, '1, '0);
    for (int i = int'(rcfp_pkg::CFG_CHAN_MID) + 1; i < (1 << CFG_IDX_W); i++)
      set_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    run_phase(PHASE_ITEMS);

    // Inverted range replaces every channel; long receiver hold-off fills the block
    settle();
    apply_settings(8'h00, rcfp_pkg::RST_ADDR_PRI, '1, '0, '1);
    hold_long = 1'b1;
    send_frame(8'h00, PAYLOAD_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}),
               8'($urandom));
    run_phase(PHASE_ITEMS);

    // Random settings
    settle();
    apply_settings(8'($urandom), 8'($urandom), CHAN_BITS'($urandom), CHAN_BITS'($urandom),
                   CHAN_BITS'($urandom));
    run_phase(PHASE_ITEMS);

    // Reset values written back; no idling from here on
    settle();
    idle_on = 1'b0;
    apply_settings(rcfp_pkg::RST_ADDR_PRI, rcfp_pkg::RST_ADDR_SEC, rcfp_pkg::RST_CHAN_MIN,
                   rcfp_pkg::RST_CHAN_MAX, rcfp_pkg::RST_CHAN_MID);
    run_phase(PHASE_ITEMS);

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
